// File: hw/rtl/via_pkg.sv
// ----------------------------------------------------------------------------
// via_pkg
// Shared types, register map and flag positions of the interface adapter.
// ----------------------------------------------------------------------------
package via_pkg;

  // Item kinds
  localparam logic [2:0] KindAccess   = 3'd0;
  localparam logic [2:0] KindTick     = 3'd1;
  localparam logic [2:0] KindPulse    = 3'd2;
  localparam logic [2:0] KindShiftIn  = 3'd3;
  localparam logic [2:0] KindShiftOut = 3'd4;

  // Register map
  localparam logic [3:0] RegOrb  = 4'd0;
  localparam logic [3:0] RegOra  = 4'd1;
  localparam logic [3:0] RegDdrb = 4'd2;
  localparam logic [3:0] RegDdra = 4'd3;
  localparam logic [3:0] RegT1cl = 4'd4;
  localparam logic [3:0] RegT1ch = 4'd5;
  localparam logic [3:0] RegT1ll = 4'd6;
  localparam logic [3:0] RegT1lh = 4'd7;
  localparam logic [3:0] RegT2l  = 4'd8;
  localparam logic [3:0] RegT2h  = 4'd9;
  localparam logic [3:0] RegSr   = 4'd10;
  localparam logic [3:0] RegAcr  = 4'd11;
  localparam logic [3:0] RegPcr  = 4'd12;
  localparam logic [3:0] RegIfr  = 4'd13;
  localparam logic [3:0] RegIer  = 4'd14;
  localparam logic [3:0] RegOraNh = 4'd15;

  // Control line codes
  localparam logic [1:0] LineCa2 = 2'd0;
  localparam logic [1:0] LineCa1 = 2'd1;
  localparam logic [1:0] LineCb2 = 2'd2;
  localparam logic [1:0] LineCb1 = 2'd3;

  // Shift modes (ACR bits 4..2)
  localparam logic [2:0] ShiftOff     = 3'd0;
  localparam logic [2:0] ShiftInExt   = 3'd3;
  localparam logic [2:0] ShiftOutPhi2 = 3'd6;
  localparam logic [2:0] ShiftOutExt  = 3'd7;

  // Interrupt flag bit positions
  localparam int unsigned FlagCa2 = 0;
  localparam int unsigned FlagCa1 = 1;
  localparam int unsigned FlagSr  = 2;
  localparam int unsigned FlagCb2 = 3;
  localparam int unsigned FlagCb1 = 4;
  localparam int unsigned FlagT2  = 5;
  localparam int unsigned FlagT1  = 6;

  // Configuration register indexes
  localparam logic [1:0] CfgPaMask  = 2'd0;
  localparam logic [1:0] CfgPbMask  = 2'd1;
  localparam logic [1:0] CfgPaFloat = 2'd2;
  localparam logic [1:0] CfgPbFloat = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic       is_write;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [1:0] pulse_line;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } item_t;

  typedef struct packed {
    logic [7:0] pa_mask;
    logic [7:0] pb_mask;
    logic [7:0] pa_float;
    logic [7:0] pb_float;
  } cfg_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       cb2_out;
  } result_t;

  // Port read: output bits from the output register, input bits from the
  // pins where the mask allows, else the float level.
  function automatic logic [7:0] port_read(logic [7:0] orr, logic [7:0] dir,
                                           logic [7:0] mask, logic [7:0] flt,
                                           logic [7:0] pins);
    logic [7:0] in_val;
    in_val = (mask & pins) | (~mask & flt);
    return (orr & dir) | (~dir & in_val);
  endfunction

endpackage

// File: hw/rtl/via_core.sv
// ----------------------------------------------------------------------------
// via_core
// Register file, timers, shift register and interrupt logic. Applies one
// item per enabled cycle and presents the resulting output beat.
// ----------------------------------------------------------------------------
module via_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  via_pkg::item_t   item_i,
  input  via_pkg::cfg_t    cfg_i,
  output via_pkg::result_t res_o
);

  logic [7:0]  ora_q, ora_d, orb_q, orb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [15:0] t1_latch_q, t1_latch_d, t1_cnt_q, t1_cnt_d, t2_cnt_q, t2_cnt_d;
  logic [7:0]  t2_latch_lo_q, t2_latch_lo_d, sr_q, sr_d;
  logic [7:0]  acr_q, acr_d, pcr_q, pcr_d;
  logic [6:0]  ifr_q, ifr_d, ier_q, ier_d;
  logic        t1_armed_q, t1_armed_d, t2_armed_q, t2_armed_d;
  logic        pb7_q, pb7_d, cb2_q, cb2_d;
  logic [7:0]  rdata;
  logic [7:0]  d;
  logic        wr;
  logic [7:0]  pbo;

  assign d  = item_i.write_data;
  assign wr = item_i.is_write;

  always_comb begin
    ora_d = ora_q;  orb_d = orb_q;  ddra_d = ddra_q;  ddrb_d = ddrb_q;
    t1_latch_d = t1_latch_q;  t1_cnt_d = t1_cnt_q;  t2_cnt_d = t2_cnt_q;
    t2_latch_lo_d = t2_latch_lo_q;  sr_d = sr_q;
    acr_d = acr_q;  pcr_d = pcr_q;  ifr_d = ifr_q;  ier_d = ier_q;
    t1_armed_d = t1_armed_q;  t2_armed_d = t2_armed_q;
    pb7_d = pb7_q;  cb2_d = cb2_q;
    rdata = 8'h00;

    unique case (item_i.kind)
      via_pkg::KindAccess: begin
        unique case (item_i.reg_addr)
          via_pkg::RegOrb: begin
            if (pcr_q[7:5] == 3'b000) ifr_d[via_pkg::FlagCb2] = 1'b0;
            ifr_d[via_pkg::FlagCb1] = 1'b0;
            if (wr) orb_d = d;
            else rdata = via_pkg::port_read(orb_q, ddrb_q, cfg_i.pb_mask,
                                            cfg_i.pb_float, item_i.port_b_pins);
          end
          via_pkg::RegOra, via_pkg::RegOraNh: begin
            if (pcr_q[3:1] == 3'b000) ifr_d[via_pkg::FlagCa2] = 1'b0;
            ifr_d[via_pkg::FlagCa1] = 1'b0;
            if (wr) ora_d = d;
            else rdata = via_pkg::port_read(ora_q, ddra_q, cfg_i.pa_mask,
                                            cfg_i.pa_float, item_i.port_a_pins);
          end
          via_pkg::RegDdrb: if (wr) ddrb_d = d; else rdata = ddrb_q;
          via_pkg::RegDdra: if (wr) ddra_d = d; else rdata = ddra_q;
          via_pkg::RegT1cl: begin
            if (wr) t1_latch_d[7:0] = d;
            else begin
              ifr_d[via_pkg::FlagT1] = 1'b0;
              rdata = t1_cnt_q[7:0];
            end
          end
          via_pkg::RegT1ch: begin
            if (wr) begin
              t1_latch_d[15:8] = d;
              ifr_d[via_pkg::FlagT1] = 1'b0;
              t1_cnt_d = {d, t1_latch_q[7:0]};
              if (!acr_q[6]) t1_armed_d = 1'b1;
            end else rdata = t1_cnt_q[15:8];
          end
          via_pkg::RegT1ll: if (wr) t1_latch_d[7:0] = d; else rdata = t1_latch_q[7:0];
          via_pkg::RegT1lh: if (wr) t1_latch_d[15:8] = d; else rdata = t1_latch_q[15:8];
          via_pkg::RegT2l: begin
            if (wr) t2_latch_lo_d = d;
            else begin
              ifr_d[via_pkg::FlagT2] = 1'b0;
              rdata = t2_cnt_q[7:0];
            end
          end
          via_pkg::RegT2h: begin
            if (wr) begin
              t2_cnt_d = {d, t2_latch_lo_q};
              ifr_d[via_pkg::FlagT2] = 1'b0;
              t2_armed_d = 1'b1;
            end else rdata = t2_cnt_q[15:8];
          end
          via_pkg::RegSr: begin
            ifr_d[via_pkg::FlagSr] = 1'b0;
            if (wr) begin
              sr_d = d;
              if (acr_q[4:2] == via_pkg::ShiftOutPhi2 && d == 8'h00) cb2_d = 1'b0;
            end else rdata = sr_q;
          end
          via_pkg::RegAcr: begin
            if (wr) begin
              if (acr_q[4] && !d[4]) cb2_d = 1'b1;
              acr_d = d;
              if (d[4:2] == via_pkg::ShiftOff) ifr_d[via_pkg::FlagSr] = 1'b0;
            end else rdata = acr_q;
          end
          via_pkg::RegPcr: if (wr) pcr_d = d; else rdata = pcr_q;
          via_pkg::RegIfr: begin
            if (wr) ifr_d = ifr_q & ~d[6:0];
            else rdata = {|(ifr_q & ier_q), ifr_q};
          end
          default: begin // IER
            if (wr) begin
              if (d[7]) ier_d = ier_q | d[6:0];
              else ier_d = ier_q & ~d[6:0];
            end else rdata = {1'b1, ier_q};
          end
        endcase
        if (wr) rdata = 8'h00;
      end
      via_pkg::KindTick: begin
        t1_cnt_d = t1_cnt_q - 16'd1;
        t2_cnt_d = t2_cnt_q - 16'd1;
        if (t1_cnt_q == 16'd1) begin
          if (acr_q[6]) begin
            t1_cnt_d = t1_latch_q;
            ifr_d[via_pkg::FlagT1] = 1'b1;
            if (acr_q[7]) pb7_d = ~pb7_q;
          end else if (t1_armed_q) begin
            t1_armed_d = 1'b0;
            ifr_d[via_pkg::FlagT1] = 1'b1;
          end
        end
        if (t2_cnt_q == 16'd1 && t2_armed_q) begin
          t2_armed_d = 1'b0;
          ifr_d[via_pkg::FlagT2] = 1'b1;
        end
      end
      via_pkg::KindPulse: begin
        unique case (item_i.pulse_line)
          via_pkg::LineCa2: ifr_d[via_pkg::FlagCa2] = 1'b1;
          via_pkg::LineCa1: ifr_d[via_pkg::FlagCa1] = 1'b1;
          via_pkg::LineCb2: ifr_d[via_pkg::FlagCb2] = 1'b1;
          default:          ifr_d[via_pkg::FlagCb1] = 1'b1;
        endcase
      end
      via_pkg::KindShiftIn: begin
        if (acr_q[4:2] == via_pkg::ShiftInExt) begin
          sr_d = d;
          ifr_d[via_pkg::FlagSr]  = 1'b1;
          ifr_d[via_pkg::FlagCb1] = 1'b1;
        end
      end
      via_pkg::KindShiftOut: begin
        if (acr_q[4:2] == via_pkg::ShiftOutExt) begin
          ifr_d[via_pkg::FlagSr]  = 1'b1;
          ifr_d[via_pkg::FlagCb1] = 1'b1;
          cb2_d = sr_q[0];
          rdata = sr_q;
        end
      end
      default: ; // unused kinds leave state alone
    endcase
  end

  // Output beat reflects state after the item
  always_comb begin
    pbo = (orb_d & ddrb_d) | (~ddrb_d & cfg_i.pb_float);
    if (acr_d[7]) pbo[7] = pb7_d;
    res_o.read_data  = rdata;
    res_o.irq        = |(ifr_d & ier_d);
    res_o.port_a_out = (ora_d & ddra_d) | (~ddra_d & cfg_i.pa_float);
    res_o.port_b_out = pbo;
    res_o.cb2_out    = cb2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ora_q <= '0;  orb_q <= '0;  ddra_q <= '0;  ddrb_q <= '0;
      t1_latch_q <= '0;  t1_cnt_q <= '0;  t2_cnt_q <= '0;
      t2_latch_lo_q <= '0;  sr_q <= '0;  acr_q <= '0;  pcr_q <= '0;
      ifr_q <= '0;  ier_q <= '0;
      t1_armed_q <= 1'b0;  t2_armed_q <= 1'b0;  pb7_q <= 1'b0;  cb2_q <= 1'b1;
    end else if (en_i) begin
      ora_q <= ora_d;  orb_q <= orb_d;  ddra_q <= ddra_d;  ddrb_q <= ddrb_d;
      t1_latch_q <= t1_latch_d;  t1_cnt_q <= t1_cnt_d;  t2_cnt_q <= t2_cnt_d;
      t2_latch_lo_q <= t2_latch_lo_d;  sr_q <= sr_d;  acr_q <= acr_d;
      pcr_q <= pcr_d;  ifr_q <= ifr_d;  ier_q <= ier_d;
      t1_armed_q <= t1_armed_d;  t2_armed_q <= t2_armed_d;
      pb7_q <= pb7_d;  cb2_q <= cb2_d;
    end
  end

endmodule

// File: hw/rtl/versatile_interface_adapter.sv
// ----------------------------------------------------------------------------
// versatile_interface_adapter
// 6522-style interface adapter: ports, two timers, shift register, IRQ.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one item per beat: a
// register access, a timer tick, a control line pulse, a shift-in byte or a
// shift-out request. Every item yields exactly one output beat on
// (out_valid_o / out_stall_i) with read data, IRQ, port levels and CB2.
// Items land in an input register; when the output side can take a beat the
// core updates its state and the beat is captured in the output register.
// The result is held there until the consumer takes it with out_stall_i low.
// One item per cycle sustained while the output is not stalled.
// The input side keeps accepting while a result is pending as long as the
// output register drains in the same cycle; a stalled output holds its beat
// and, once the input register is full too, in_stall_o rises.
// Configuration (cfg_we_i) writes the pin masks and float levels; do it
// only with no item in flight. Reset clears the core state (CB2 idles high),
// sets config registers to FFh and empties both registers; no clearing pass.
// ----------------------------------------------------------------------------
module versatile_interface_adapter (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic       is_write_i,
  input  logic [3:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic [1:0] pulse_line_i,
  input  logic [7:0] port_a_pins_i,
  input  logic [7:0] port_b_pins_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       irq_o,
  output logic [7:0] port_a_out_o,
  output logic [7:0] port_b_out_o,
  output logic       cb2_out_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  via_pkg::item_t   item_q;
  logic             in_valid_q;
  via_pkg::result_t res_d, res_q;
  logic             out_valid_q;
  via_pkg::cfg_t    cfg_q;
  logic             out_ready, fire, accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) in_valid_q <= 1'b1;
      else if (fire) in_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind        <= kind_i;
      item_q.is_write    <= is_write_i;
      item_q.reg_addr    <= reg_addr_i;
      item_q.write_data  <= write_data_i;
      item_q.pulse_line  <= pulse_line_i;
      item_q.port_a_pins <= port_a_pins_i;
      item_q.port_b_pins <= port_b_pins_i;
    end
    if (fire) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pa_mask: 8'hFF, pb_mask: 8'hFF, pa_float: 8'hFF, pb_float: 8'hFF};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        via_pkg::CfgPaMask:  cfg_q.pa_mask  <= cfg_wdata_i;
        via_pkg::CfgPbMask:  cfg_q.pb_mask  <= cfg_wdata_i;
        via_pkg::CfgPaFloat: cfg_q.pa_float <= cfg_wdata_i;
        default:             cfg_q.pb_float <= cfg_wdata_i;
      endcase
    end
  end

  via_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = res_q.read_data;
  assign irq_o        = res_q.irq;
  assign port_a_out_o = res_q.port_a_out;
  assign port_b_out_o = res_q.port_b_out;
  assign cb2_out_o    = res_q.cb2_out;

endmodule
